/* rtl/radix_integer_to_ascii_defines.svh */
// radix_integer_to_ascii_defines.svh: assertion macros for the converter checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef RADIX_INTEGER_TO_ASCII_DEFINES_SVH
`define RADIX_INTEGER_TO_ASCII_DEFINES_SVH

// same-cycle implication
`define RITA_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication
`define RITA_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/rita_pkg.sv */
// rita_pkg: types, constants and the ascii mapping of the radix converter
// used by every rtl file of the block except rita_ram; depends on nothing
package rita_pkg;

  localparam int unsigned IN_VALUE_W  = 64;
  localparam int unsigned VALUE_WIDTH = 64;
  localparam int unsigned MAX_DIGITS  = 64;
  localparam int unsigned BUF_DEPTH   = 64;
  localparam int unsigned BUF_AW      = $clog2(BUF_DEPTH);
  localparam int unsigned CNT_W       = $clog2(BUF_DEPTH + 1);
  localparam int unsigned DIGIT_LIMIT = (MAX_DIGITS > BUF_DEPTH) ? BUF_DEPTH : MAX_DIGITS;
  localparam int unsigned STEP_W      = $clog2(VALUE_WIDTH);
  localparam int unsigned DIGIT_W     = 6;
  localparam int unsigned CHAR_W      = 7;

  localparam logic [DIGIT_W-1:0] RADIX_MIN    = 6'd2;
  localparam logic [DIGIT_W-1:0] RADIX_MAX    = 6'd36;
  localparam logic [DIGIT_W-1:0] LAST_NUMERAL = 6'd9;
  localparam logic [CHAR_W:0]    LOWER_OFFSET = 8'd87;
  localparam logic [CHAR_W:0]    UPPER_OFFSET = 8'd55;
  localparam logic [CHAR_W:0]    NUM_OFFSET   = 8'd48;

  typedef struct packed {
    logic [IN_VALUE_W-1:0] value;
    logic [DIGIT_W-1:0]    radix;
    logic                  mode;
  } rita_req_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_char;
  } rita_rsp_t;

  typedef struct packed {
    logic                   start;
    logic [VALUE_WIDTH-1:0] dividend;
    logic [DIGIT_W-1:0]     radix;
  } rita_div_cmd_t;

  typedef struct packed {
    logic                   done;
    logic [VALUE_WIDTH-1:0] quotient;
    logic [DIGIT_W-1:0]     remainder;
  } rita_div_res_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [DIGIT_W-1:0] d,
                                                 input logic upper);
    logic [CHAR_W:0] sum;
    if (d > LAST_NUMERAL) begin
      sum = {2'b00, d} + (upper ? UPPER_OFFSET : LOWER_OFFSET);
    end else begin
      sum = {2'b00, d} + NUM_OFFSET;
    end
    return sum[CHAR_W-1:0];
  endfunction

endpackage

/* rtl/rita_ram.sv */
// rita_ram: generic single write port ram with registered read
// no package dependency
module rita_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/rita_div.sv */
// rita_div: bit-serial restoring divider, one quotient bit per cycle
// depends on rita_pkg for widths and the command and result structs
module rita_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rita_pkg::rita_div_cmd_t cmd_i,
  output rita_pkg::rita_div_res_t res_o
);
  import rita_pkg::*;

  logic                   busy_q, busy_d;
  logic                   done_q, done_d;
  logic [STEP_W-1:0]      step_q, step_d;
  logic [VALUE_WIDTH-1:0] dvd_q, dvd_d;
  logic [DIGIT_W-1:0]     rem_q, rem_d;
  logic [DIGIT_W-1:0]     radix_q, radix_d;
  logic [DIGIT_W:0]       trial;
  logic [DIGIT_W:0]       diff;
  logic                   qbit;

  always_comb begin
    trial   = {rem_q, dvd_q[VALUE_WIDTH-1]};
    diff    = trial - {1'b0, radix_q};
    qbit    = (trial >= {1'b0, radix_q});
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    radix_d = radix_q;
    priority if (cmd_i.start) begin
      busy_d  = 1'b1;
      step_d  = STEP_W'(VALUE_WIDTH - 1);
      dvd_d   = cmd_i.dividend;
      rem_d   = '0;
      radix_d = cmd_i.radix;
    end else if (busy_q) begin
      dvd_d  = {dvd_q[VALUE_WIDTH-2:0], qbit};
      rem_d  = qbit ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      step_d = step_q - 1'b1;
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end else begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk_i) begin
    dvd_q   <= dvd_d;
    rem_q   <= rem_d;
    radix_q <= radix_d;
  end

  assign res_o.done      = done_q;
  assign res_o.quotient  = dvd_q;
  assign res_o.remainder = rem_q;

endmodule

/* rtl/radix_integer_to_ascii.sv */
// radix_integer_to_ascii: unsigned integer to ascii digits in radix 2 to 36
// depends on rita_pkg, rita_div and rita_ram
//
// One request carries a value, a radix and a letter case; the block answers with
// the digits as ascii characters, most significant first, the final one flagged
// by last_char. Zero gives the single character '0', radix values outside 2..36
// saturate to the nearest end. Each digit is worked out in the bit-serial divider
// (one quotient bit per cycle), and each character then goes through the registered
// digit buffer read (S_READ, then S_EMIT) into the output register. The input
// stalls until the last character of a number is loaded there; the output register
// lets the last character of one number wait while the next request is taken.
module radix_integer_to_ascii (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rita_pkg::rita_req_t in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rita_pkg::rita_rsp_t out_rsp_o
);
  import rita_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_READ = 2'd2;
  localparam logic [1:0] S_EMIT = 2'd3;

  logic [1:0]             state_q, state_d;
  logic [CNT_W-1:0]       n_q, n_d;
  logic [CNT_W-1:0]       n_next;
  logic [BUF_AW-1:0]      idx_q, idx_d;
  logic                   upper_q, upper_d;
  logic [DIGIT_W-1:0]     radix_q, radix_d;
  logic [DIGIT_W-1:0]     radix_sat;
  logic [VALUE_WIDTH-1:0] value_in;
  logic                   in_acc;
  logic                   out_free;
  logic                   load;
  logic                   out_valid_q, out_valid_d;
  rita_rsp_t              rsp_q, rsp_d;
  rita_div_cmd_t          div_cmd;
  rita_div_res_t          div_res;
  logic                   ram_we;
  logic [BUF_AW-1:0]      ram_waddr;
  logic [DIGIT_W-1:0]     ram_wdata;
  logic                   ram_re;
  logic [DIGIT_W-1:0]     ram_rdata;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign value_in   = in_req_i.value[VALUE_WIDTH-1:0];
  assign n_next     = n_q + 1'b1;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    priority if (in_req_i.radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (in_req_i.radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = in_req_i.radix;
    end
  end

  always_comb begin
    state_d          = state_q;
    n_d              = n_q;
    idx_d            = idx_q;
    upper_d          = upper_q;
    radix_d          = radix_q;
    div_cmd.start    = 1'b0;
    div_cmd.dividend = div_res.quotient;
    div_cmd.radix    = radix_q;
    ram_we           = 1'b0;
    ram_waddr        = n_q[BUF_AW-1:0];
    ram_wdata        = div_res.remainder;
    ram_re           = 1'b0;
    load             = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          upper_d = in_req_i.mode;
          radix_d = radix_sat;
          if (value_in == '0) begin
            // zero is the single digit 0
            ram_we    = 1'b1;
            ram_waddr = '0;
            ram_wdata = '0;
            n_d       = CNT_W'(1);
            idx_d     = '0;
            state_d   = S_READ;
          end else begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = value_in;
            div_cmd.radix    = radix_sat;
            n_d              = '0;
            state_d          = S_DIV;
          end
        end
      end
      S_DIV: begin
        if (div_res.done) begin
          ram_we = 1'b1;
          n_d    = n_next;
          if ((div_res.quotient != '0) && (n_next < CNT_W'(DIGIT_LIMIT))) begin
            div_cmd.start = 1'b1;
          end else begin
            idx_d   = n_q[BUF_AW-1:0];
            state_d = S_READ;
          end
        end
      end
      S_READ: begin
        ram_re  = 1'b1;
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          load = 1'b1;
          if (idx_q == '0) begin
            state_d = S_IDLE;
          end else begin
            idx_d   = idx_q - 1'b1;
            state_d = S_READ;
          end
        end
      end
    endcase
  end

  always_comb begin
    out_valid_d      = out_valid_q && out_stall_i;
    rsp_d            = rsp_q;
    rsp_d.digit_char = to_ascii(ram_rdata, upper_q);
    rsp_d.last_char  = (idx_q == '0);
    if (load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // request payload, no reset
  always_ff @(posedge clk_i) begin
    upper_q <= upper_d;
    radix_q <= radix_d;
    if (load) begin
      rsp_q <= rsp_d;
    end
  end

  rita_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (div_cmd),
    .res_o  (div_res)
  );

  rita_ram #(
    .Width (DIGIT_W),
    .Depth (BUF_DEPTH)
  ) u_digit_buf (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (idx_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = rsp_q;

endmodule

/* rtl/rita_checker.sv */
// rita_checker: port-level checks of radix_integer_to_ascii, bound to the top level
// depends on rita_pkg and radix_integer_to_ascii_defines.svh
`include "radix_integer_to_ascii_defines.svh"

module rita_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input rita_pkg::rita_req_t in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input rita_pkg::rita_rsp_t out_rsp_o
);
  import rita_pkg::*;

  logic [CHAR_W-1:0] c;
  logic              char_ok;
  logic              in_taken;

  assign c        = out_rsp_o.digit_char;
  assign char_ok  = ((c >= 7'd48) && (c <= 7'd57)) || ((c >= 7'd65) && (c <= 7'd90)) ||
                    ((c >= 7'd97) && (c <= 7'd122));
  assign in_taken = in_valid_i && !in_stall_o;

  // stalled output request holds
  `RITA_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_rsp_o), "output request changed while stalled")
  // only digits and letters come out
  `RITA_ASSERT_IMPL(a_char_range, out_valid_o, char_ok, "character outside digit and letter range")
  // one number at a time
  `RITA_ASSERT_NEXT(a_busy_after_req, in_taken, in_stall_o, "input not stalled after taking a request")
  // a number still in flight keeps the input stalled
  `RITA_ASSERT_IMPL(a_busy_mid_string, out_valid_o && !out_rsp_o.last_char, in_stall_o, "new request possible before the last character")

endmodule

bind radix_integer_to_ascii rita_checker u_rita_checker (.*);

/* sim/rita_digit_checker.sv */
// rita_digit_checker: watches both channels of the radix converter and predicts its digits
// each accepted request is turned into the ascii characters it must produce, then compared
// depends on rita_pkg
module rita_digit_checker (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  rita_pkg::rita_req_t in_req_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  rita_pkg::rita_rsp_t out_rsp_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  import rita_pkg::*;

  rita_rsp_t expected_chars[$];
  rita_rsp_t oldest_char;
  int        fail_total;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
    fail_total   = 0;
  end

  function automatic void note_failure(input string msg);
    fail_total++;
    if (fail_total <= 10) begin
      $display("%s", msg);
    end
  endfunction

  // repeated division, remainders kept least significant first, emitted in reverse
  function automatic void queue_digit_chars(input rita_req_t req);
    logic [63:0]        quot;
    logic [5:0]         base;
    logic [5:0]         digits[64];
    logic [5:0]         d;
    logic [7:0]         code;
    rita_rsp_t          rsp;
    int                 n;
    quot = req.value;
    base = req.radix;
    n    = 0;
    if (base < 6'd2) begin
      base = 6'd2;
    end
    if (base > 6'd36) begin
      base = 6'd36;
    end
    if (quot == 64'd0) begin
      digits[0] = 6'd0;
      n         = 1;
    end else begin
      while (quot != 64'd0 && n < 64) begin
        digits[n] = 6'(quot % {58'd0, base});
        quot      = quot / {58'd0, base};
        n++;
      end
    end
    for (int k = 0; k < n; k++) begin
      d = digits[n - 1 - k];
      if (d > 6'd9) begin
        code = {2'b00, d} + (req.mode ? UPPER_OFFSET : LOWER_OFFSET);
      end else begin
        code = {2'b00, d} + NUM_OFFSET;
      end
      rsp.digit_char = code[6:0];
      rsp.last_char  = (k == n - 1);
      expected_chars.push_back(rsp);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_chars.delete();
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          note_failure($sformatf("checker: unexpected char %h last %b with nothing pending",
                                 out_rsp_i.digit_char, out_rsp_i.last_char));
        end else begin
          oldest_char = expected_chars.pop_front();
          if (oldest_char.digit_char !== out_rsp_i.digit_char ||
              oldest_char.last_char !== out_rsp_i.last_char) begin
            note_failure($sformatf("checker: expected char %h last %b, got char %h last %b",
                                   oldest_char.digit_char, oldest_char.last_char,
                                   out_rsp_i.digit_char, out_rsp_i.last_char));
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        queue_digit_chars(in_req_i);
      end
      pending_o    <= expected_chars.size();
      fail_count_o <= fail_total;
    end
  end

endmodule

/* sim/tb.sv */
// tb: drives requests into radix_integer_to_ascii and gives the verdict
// directed corner values first, then random values in every radix with bursty input and stalls
// depends on rita_pkg, the converter rtl and rita_digit_checker
module tb;
  import rita_pkg::*;

  localparam int IDLE_LIMIT  = 20000;
  localparam int DRAIN       = 300;
  localparam int RANDOM_REQS = 189;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  rita_req_t in_req    = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  rita_rsp_t out_rsp;
  int        fails;
  int        pending;
  int        burst_left = 0;
  int        idle_cycles = 0;
  int        stall_mode = 0;
  int        stall_left = 0;

  initial begin
    forever #6 clk = ~clk;
  end

  radix_integer_to_ascii i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  rita_digit_checker i_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_req_i     (in_req),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_rsp_i    (out_rsp),
    .fail_count_o (fails),
    .pending_o    (pending)
  );

  // receiver stall pattern, switching between free flow, light, heavy and periodic stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(3, 0);
      stall_left <= $urandom_range(300, 20);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(3, 0) == 0);
      2: out_stall <= ($urandom_range(3, 0) != 0);
      default: out_stall <= stall_left[2];
    endcase
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  task automatic send_req(input logic [63:0] value, input logic [5:0] radix, input logic mode);
    rita_req_t req;
    req.value = value;
    req.radix = radix;
    req.mode  = mode;
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      if ($urandom_range(7, 0) == 0) begin
        repeat ($urandom_range(150, 60)) @(posedge clk);
      end else begin
        repeat ($urandom_range(25, 1)) @(posedge clk);
      end
      burst_left = $urandom_range(12, 0);
    end
  endtask

  task automatic wait_all_chars();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    logic [63:0] v;
    int          sel;
    int          bits;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(64'd0, 6'd2, 1'b0);
    send_req(64'd0, 6'd36, 1'b1);
    send_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd2, 1'b0);
    send_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd36, 1'b0);
    send_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd36, 1'b1);
    send_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd16, 1'b1);
    send_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd10, 1'b0);
    send_req(64'hFFFF_FFFF_FFFF_FFFF, 6'd3, 1'b1);
    send_req(64'h8000_0000_0000_0000, 6'd2, 1'b1);
    send_req(64'd1, 6'd2, 1'b0);
    send_req(64'd9, 6'd10, 1'b0);
    send_req(64'd10, 6'd11, 1'b0);
    send_req(64'd35, 6'd36, 1'b0);
    send_req(64'd35, 6'd36, 1'b1);
    send_req(64'd36, 6'd36, 1'b0);
    send_req(64'd7, 6'd8, 1'b1);
    send_req(64'h0000_0000_DEAD_BEEF, 6'd16, 1'b0);
    send_req(64'h0000_0000_DEAD_BEEF, 6'd16, 1'b1);
    send_req(64'd12345678, 6'd10, 1'b1);
    send_req(64'h5555_5555_5555_5555, 6'd4, 1'b0);
    send_req(64'hAAAA_AAAA_AAAA_AAAA, 6'd32, 1'b1);

    // hold off until every character of the directed requests has come out
    in_valid <= 1'b0;
    wait_all_chars();

    for (int i = 0; i < RANDOM_REQS; i++) begin
      sel = $urandom_range(99, 0);
      v   = {$urandom, $urandom};
      if (sel < 15) begin
        v = v;
      end else if (sel < 25) begin
        v = 64'($urandom_range(40, 0));
      end else begin
        bits = $urandom_range(40, 1);
        v    = v >> (64 - bits);
      end
      send_req(v, 6'($urandom_range(36, 2)), 1'($urandom_range(1, 0)));
    end

    in_valid <= 1'b0;
    wait_all_chars();
    repeat (DRAIN) @(posedge clk);
    if (fails == 0 && pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

/* radix_integer_to_ascii.f */
+incdir+rtl
rtl/rita_pkg.sv
rtl/rita_ram.sv
rtl/rita_div.sv
rtl/radix_integer_to_ascii.sv
rtl/rita_checker.sv
sim/rita_digit_checker.sv
sim/tb.sv
